// File: sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the SHA-256 stream hasher
// Round constants, initial hash values, and the front/back queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

    typedef logic [31:0] word_t;

    // Queue entry: one message byte plus its end-of-message flag.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_last;
    } beat_t;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PAD,
        ST_COMPRESS,
        ST_ADD,
        ST_EMIT
    } core_state_t;

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

`default_nettype wire

// File: sv/sha_fifo.sv
// ----------------------------------------------------------------------------
// sha_fifo: input beat queue
// Small register FIFO between the byte front end and the compression core.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_fifo #(
    parameter int DEPTH = 4
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  wire sha_pkg::beat_t push_data,
    output logic               full,
    input  wire                pop,
    output sha_pkg::beat_t     pop_data,
    output logic               empty
);
    import sha_pkg::*;

    localparam int AW = $clog2(DEPTH);

    beat_t           mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
        end
    end

endmodule

`default_nettype wire

// File: sv/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core: block assembly, padding and round engine
// Packs bytes into 16 words, pads on the last byte, runs one round a cycle
// with a rolling 16-word schedule, then streams the digest out.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_core (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    input  wire sha_pkg::beat_t in_data,
    output logic               in_ready,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [31:0]        out_word,
    output logic [2:0]         out_index,
    output logic               out_last
);
    import sha_pkg::*;

    core_state_t state_reg, state_next;

    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       w_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  round_reg;
    logic        final_reg;   // current compression is the length block
    logic        extra_reg;   // another padding block follows
    logic [2:0]  emit_reg;

    // round datapath
    word_t t1, t2, s0, s1, w_new, ch, maj;
    always_comb
    begin
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
              + ch + ROUND_K[round_reg] + w_reg[0];
        t2  = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22)) + maj;
        s0  = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1  = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
    end

    assign in_ready  = (state_reg == ST_COLLECT);
    assign out_valid = (state_reg == ST_EMIT);
    assign out_word  = h_reg[emit_reg];
    assign out_index = emit_reg;
    assign out_last  = (emit_reg == 3'd7);

    logic take;
    assign take = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (take)
                begin
                    if (fill_reg == 6'd63)
                    begin
                        state_next = ST_COMPRESS;
                    end
                    else if (in_data.is_last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:      state_next = ST_COMPRESS;
            ST_COMPRESS: if (round_reg == 6'd63) state_next = ST_ADD;
            ST_ADD:
            begin
                priority if (final_reg)            state_next = ST_EMIT;
                else if (extra_reg)                state_next = ST_PAD;
                else                               state_next = ST_COLLECT;
            end
            ST_EMIT:     if (out_ready && emit_reg == 3'd7) state_next = ST_COLLECT;
            default:     state_next = ST_COLLECT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // word slot for a byte position
    function automatic word_t put_byte(input word_t w, input logic [1:0] lane,
                                       input logic [7:0] b);
        word_t r;
        r = w;
        r[(3 - lane) * 8 +: 8] = b;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_H[i];
            end
            fill_reg  <= '0;
            len_reg   <= '0;
            round_reg <= '0;
            final_reg <= 1'b0;
            extra_reg <= 1'b0;
            emit_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_COLLECT:
                begin
                    if (take)
                    begin
                        w_reg[fill_reg[5:2]] <= put_byte(w_reg[fill_reg[5:2]],
                                                         fill_reg[1:0], in_data.byte_value);
                        fill_reg <= fill_reg + 1'b1;
                        for (int i = 0; i < 8; i++)
                        begin
                            v_reg[i] <= h_reg[i];
                        end
                        round_reg <= '0;
                        if (fill_reg == 6'd63)
                        begin
                            len_reg   <= len_reg + 64'd512;
                            final_reg <= 1'b0;
                            // last byte fills the block: pad after compress
                            extra_reg <= in_data.is_last;
                        end
                        else if (in_data.is_last)
                        begin
                            len_reg  <= len_reg + {55'd0, fill_reg + 1'b1, 3'd0};
                            fill_reg <= fill_reg + 1'b1;
                        end
                    end
                end
                ST_PAD:
                begin
                    // fill_reg: bytes held; pad byte at fill_reg unless this
                    // is the follow-up block after an overflowing pad.
                    for (int j = 0; j < 16; j++)
                    begin
                        word_t wv;
                        wv = w_reg[j];
                        for (int b = 0; b < 4; b++)
                        begin
                            if (6'(j * 4 + b) > fill_reg ||
                                (6'(j * 4 + b) == fill_reg && extra_reg && !final_reg
                                 && fill_reg == 6'd0 && 1'b0))
                            begin
                                wv[(3 - b) * 8 +: 8] = 8'h00;
                            end
                        end
                        w_reg[j] <= wv;
                    end
                    if (extra_reg)
                    begin
                        // empty buffer block: pad byte only if not yet placed
                        for (int j = 0; j < 16; j++)
                        begin
                            w_reg[j] <= '0;
                        end
                        if (fill_reg == 6'd0)
                        begin
                            w_reg[0] <= {PAD_BYTE, 24'd0};
                        end
                        w_reg[14] <= len_reg[63:32];
                        w_reg[15] <= len_reg[31:0];
                        final_reg <= 1'b1;
                        extra_reg <= 1'b0;
                    end
                    else
                    begin
                        w_reg[fill_reg[5:2]] <= put_byte(w_reg[fill_reg[5:2]] &
                            ~(32'hffffffff >> (fill_reg[1:0] * 8)), fill_reg[1:0], PAD_BYTE);
                        if (fill_reg < LEN_OFFSET)
                        begin
                            w_reg[14] <= len_reg[63:32];
                            w_reg[15] <= len_reg[31:0];
                            final_reg <= 1'b1;
                        end
                        else
                        begin
                            final_reg <= 1'b0;
                            extra_reg <= 1'b1;
                            // mark pad byte already placed
                            fill_reg  <= 6'd1;
                        end
                        if (fill_reg >= LEN_OFFSET && fill_reg[5:2] != 4'd15)
                        begin
                            w_reg[15] <= '0;
                        end
                        if (fill_reg >= LEN_OFFSET && fill_reg[5:2] == 4'd14)
                        begin
                            w_reg[15] <= '0;
                        end
                    end
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i];
                    end
                    round_reg <= '0;
                end
                ST_COMPRESS:
                begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    for (int j = 0; j < 15; j++)
                    begin
                        w_reg[j] <= w_reg[j + 1];
                    end
                    w_reg[15] <= w_new;
                    round_reg <= round_reg + 1'b1;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (extra_reg)
                    begin
                        fill_reg <= (final_reg) ? 6'd0 : fill_reg;
                    end
                    emit_reg <= '0;
                end
                ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        emit_reg <= emit_reg + 1'b1;
                        if (emit_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= INIT_H[i];
                            end
                            fill_reg  <= '0;
                            len_reg   <= '0;
                            final_reg <= 1'b0;
                            extra_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher: byte-stream SHA-256 with digest word output
// Front queue takes bytes; the core packs, pads, compresses and emits.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                      | tuser | tlast
//  s_axis  | in  | [7:0] byte_value           | -     | is_last
//  m_axis  | out | [31:0] digest_word,[34:32] | -     | last_word
//          |     | word_index (padded to 40)  |       |
//
//  One byte is absorbed per cycle while a block fills; a full block then
//  holds the core in the round and add states, run by the single shared
//  round unit. The final byte adds one or two padded blocks and eight
//  digest beats. The input queue keeps taking beats during compression until
//  it fills. Reset (rst_n low, asynchronous) loads the initial hash values
//  and empties the queue. An output stall holds the core in digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast
);
    import sha_pkg::*;

    beat_t q_in, q_out;
    logic  q_full, q_empty, core_ready;
    logic [31:0] word;
    logic [2:0]  index;

    assign q_in.byte_value = s_axis_tdata;
    assign q_in.is_last    = s_axis_tlast;
    assign s_axis_tready   = !q_full;

    sha_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid),
        .push_data (q_in),
        .full      (q_full),
        .pop       (core_ready),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    sha_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!q_empty),
        .in_data   (q_out),
        .in_ready  (core_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (word),
        .out_index (index),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, index, word};

endmodule

`default_nettype wire

// File: sv/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker: port-level checks for the stream hasher
// Watches digest beat numbering, output stability and pad bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata,
    input wire        m_axis_tlast
);
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
        else $error("tlast not on word 7");

    a_next_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
        else $error("digest words not consecutive");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled beat changed");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:35] == 5'd0))
        else $error("pad bits nonzero");
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (.*);

`default_nettype wire

// File: verif/sha256_stream_hasher_test.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_test: self-checking bench for the byte-stream hasher
// Messages go in as byte beats; an internal SHA-256 predictor computes the
// eight digest words per message and the output beats are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_stream_hasher_test;

    import sha_pkg::*;

    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    wire         s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    wire         m_axis_tvalid;
    logic        m_axis_tready;
    wire  [39:0] m_axis_tdata;
    wire         m_axis_tlast;

    sha256_stream_hasher uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    localparam int IDLE_PCT   = 23;
    localparam int STALL_LEN  = 300;
    localparam int WATCH_MAX  = 20000;

    // round constants (standard SHA-256)
    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // predictor state
    logic [31:0] chain_h [8];
    logic [7:0]  blk [64];
    int unsigned blk_fill;
    logic [63:0] done_bits;

    beat_t        byte_queue [$];
    digest_beat_t digest_queue [$];

    int  errors;
    int  bytes_sent;
    int  words_seen;
    int  messages;
    int  watch;
    bit  drv_pause;        // sender holds off (drain)
    bit  no_idle;          // stretch with no random idling
    int  stall_left;       // receiver long hold-off, counted in monitor
    bit  stall_req;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_blk();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        {a, b, c, d, e, f, g, h} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
                                    chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + KTAB[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
            chain_h[i] = H_START[i];
        blk_fill  = 0;
        done_bits = '0;
    endtask

    // absorb one accepted byte; on the final byte pad and queue the digest
    task automatic absorb_byte(input logic [7:0] value, input logic fin);
        digest_beat_t d;
        int unsigned  n;
        blk[blk_fill] = value;
        blk_fill++;
        if (blk_fill == 64)
        begin
            compress_blk();
            done_bits += 64'd512;
            blk_fill = 0;
        end
        if (fin)
        begin
            n = blk_fill;
            done_bits += 64'(n) * 8;
            blk[n] = 8'h80;
            n++;
            if (n > 56)
            begin
                while (n < 64)
                begin
                    blk[n] = 8'h00;
                    n++;
                end
                compress_blk();
                n = 0;
            end
            while (n < 56)
            begin
                blk[n] = 8'h00;
                n++;
            end
            for (int i = 7; i >= 0; i--)
            begin
                blk[n] = done_bits[8*i +: 8];
                n++;
            end
            compress_blk();
            for (int i = 0; i < 8; i++)
            begin
                d.digest_word = chain_h[i];
                d.word_index  = 3'(i);
                d.last_word   = (i == 7);
                digest_queue.push_back(d);
            end
            messages++;
            restart_hash();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    task automatic queue_message(input int len, input int mode);
        beat_t b;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0:       b.byte_value = 8'($urandom_range(0, 255));
                1:       b.byte_value = 8'hff;
                2:       b.byte_value = 8'h00;
                default: b.byte_value = 8'(1 << (i % 8));
            endcase
            b.is_last = (i == len - 1);
            byte_queue.push_back(b);
        end
    endtask

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // driver: offer beats from the pending queue, with random idling
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_byte(s_axis_tdata, s_axis_tlast);
                bytes_sent++;
                void'(byte_queue.pop_front());
            end
            // only change the offer when nothing is pending on the bus
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (byte_queue.size() > 0 && !drv_pause
                    && (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= byte_queue[0].byte_value;
                    s_axis_tlast  <= byte_queue[0].is_last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check each accepted digest beat and drive the receiver side
    always @(posedge clk or negedge rst_n)
    begin
        digest_beat_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            watch         <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                words_seen++;
                if (digest_queue.size() == 0)
                    report_mismatch("unexpected beat", m_axis_tdata, 0);
                else
                begin
                    want = digest_queue.pop_front();
                    if (m_axis_tdata[31:0] !== want.digest_word)
                        report_mismatch("digest_word", m_axis_tdata[31:0], want.digest_word);
                    if (m_axis_tdata[34:32] !== want.word_index)
                        report_mismatch("word_index", m_axis_tdata[34:32], want.word_index);
                    if (m_axis_tlast !== want.last_word)
                        report_mismatch("last_word", m_axis_tlast, want.last_word);
                    if (m_axis_tdata[39:35] !== 5'b0)
                        report_mismatch("tdata padding", m_axis_tdata[39:35], 0);
                end
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                watch <= 0;
            else
                watch <= watch + 1;
            if (stall_req && stall_left == 0)
            begin
                stall_left    <= STALL_LEN;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= (stall_left == 1);
            end
            else
                m_axis_tready <= no_idle || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    always @(posedge clk)
    begin
        if (watch >= WATCH_MAX)
        begin
            $display("timeout: no beat accepted for %0d cycles", WATCH_MAX);
            $display("FAIL sha256_stream_hasher");
            $finish;
        end
    end

    task automatic wait_drained();
        while (byte_queue.size() > 0 || digest_queue.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int total;
        errors     = 0;
        bytes_sent = 0;
        words_seen = 0;
        messages   = 0;
        drv_pause  = 0;
        no_idle    = 0;
        stall_req  = 0;
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;
        restart_hash();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        #1 rst_n = 1'b1;

        // directed: single byte extremes, short walking-bit messages, 55/56/63/64/65-byte pad boundaries
        queue_message(1, 2);
        queue_message(1, 1);
        queue_message(3, 3);
        queue_message(8, 3);
        total = 13;
        wait_drained();
        queue_message(55, 0);
        queue_message(56, 1);
        queue_message(63, 0);
        queue_message(64, 2);
        queue_message(65, 0);

        // long receiver hold-off while the sender keeps offering
        @(posedge clk);
        stall_req = 1;
        wait (stall_left > 0);
        stall_req = 0;
        wait_drained();
        total += 55 + 56 + 63 + 64 + 65;

        // stretch with no idling on either side
        no_idle = 1;
        queue_message(24, 0);
        wait_drained();
        no_idle = 0;
        total += 24;

        // random short messages up to the byte budget
        while (total < 350)
        begin
            int len;
            len = $urandom_range(1, 20);
            queue_message(len, 0);
            total += len;
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
        wait_drained();
        repeat (300) @(posedge clk);

        $display("covered %0d bytes in %0d messages, %0d digest words checked",
                 bytes_sent, messages, words_seen);
        $display("pad boundaries 55/56/63/64/65 bytes, extreme bytes, long output stall");
        if (errors == 0 && digest_queue.size() == 0)
            $display("PASS sha256_stream_hasher");
        else
            $display("FAIL sha256_stream_hasher");
        $finish;
    end

endmodule
